[sv/scp_pkg.sv]
// Package with shared constants, codes and types of the sparse index champion chooser.
package scp_pkg;

   localparam int INDEX_ENTRIES = 1024;
   localparam int LIST_MAX      = 16;
   localparam int CAND_MAX      = 256;
   localparam int IN_MAX        = 256;

   localparam int IDX_W   = $clog2(INDEX_ENTRIES);
   localparam int USED_W  = $clog2(INDEX_ENTRIES + 1);
   localparam int LIST_W  = $clog2(LIST_MAX);
   localparam int LEN_W   = $clog2(LIST_MAX + 1);
   localparam int CAND_W  = $clog2(CAND_MAX);
   localparam int IN_W    = $clog2(IN_MAX);
   localparam int INSZ_W  = $clog2(IN_MAX + 1);
   localparam int MEM_AW  = IDX_W + LIST_W;
   localparam int MEM_DEPTH = INDEX_ENTRIES * (2 ** LIST_W);

   localparam int FP_W     = 64;
   localparam int ID_W     = 8;
   localparam int REQ_W    = 3;
   localparam int STAT_W   = 3;
   localparam int CFG_W    = 4;
   localparam int ROUND_W  = 4;
   localparam int SCORE_W  = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [SCORE_W-1:0] SCORE_TOP = SCORE_W'(511);

   localparam logic [CFG_W-1:0] CHAMPS_RESET = CFG_W'(10);
   localparam logic [CFG_W-1:0] NIBBLE_RESET = CFG_W'(15);

   localparam logic [CSR_IDX_W-1:0] CSR_CHAMPS_MAX  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOOK_NIBBLE = 1'b1;

   localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CHOOSE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_START  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_IDX_FULL  = 3'd1;
   localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd2;
   localparam logic [STAT_W-1:0] ST_IN_FULL   = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_HOOK  = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [FP_W-1:0]  fingerprint;
      logic [ID_W-1:0]  candidate_id;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               champ_valid;
      logic [ID_W-1:0]    champ_id;
      logic [SCORE_W-1:0] champ_score;
   } rsp_item_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_LK_RD,
      S_LK_CMP,
      S_ADD_NEW,
      S_ADD_LEN,
      S_ADD_DUP_RD,
      S_ADD_DUP_CMP,
      S_CLR,
      S_CH_NEXT,
      S_CH_KEY,
      S_CH_LEN,
      S_CH_MEM_RD,
      S_CH_MEM,
      S_CH_SC,
      S_UNDO_RD,
      S_UNDO_MEM,
      S_UNDO_SC,
      S_FIN
   } scp_state_type;

   typedef struct packed {
      logic              accept;
      logic              set_res;
      logic [STAT_W-1:0] res_status;
      logic              lk_start;
      logic              lk_step;
      logic              add_new;
      logic              add_append;
      logic              len_latch;
      logic              s_clr;
      logic              s_step;
      logic              mem_use_t;
      logic              append_do;
      logic              start_round;
      logic              clr_in;
      logic              ch_init;
      logic              clr_step;
      logic              i_clr;
      logic              i_step;
      logic              target_load;
      logic              mark_found;
      logic              sc_latch;
      logic              sc_inc;
      logic              sc_dec;
      logic              t_step;
      logic              choose_fin;
      logic              rsp_load;
   } scp_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_code;
      logic             cand_bad;
      logic             lk_end;
      logic             key_hit;
      logic             used_full;
      logic             s_end;
      logic             list_full;
      logic             dup_hit;
      logic             round_done;
      logic             clr_end;
      logic             i_end;
      logic             i_found;
      logic             mem_bad;
      logic             mem_last;
      logic             t_end;
      logic             rsp_free;
   } scp_stat_type;

endpackage

[sv/scp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module scp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/scp_ctrl.sv]
// Controller state machine that sequences lookups, list walks and score updates.
module scp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scp_pkg::scp_stat_type stat,
   output scp_pkg::scp_cmd_type  cmd
);

   scp_pkg::scp_state_type state_ff, state_in;
   logic                   mode_ff, mode_in;  // high while a lookup serves a choose

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scp_pkg::S_IDLE;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         scp_pkg::S_IDLE: begin
            if (req_valid) state_in = scp_pkg::S_DISPATCH;
         end
         scp_pkg::S_DISPATCH: begin
            case (stat.req_code)
               scp_pkg::REQ_ADD: begin
                  mode_in  = 1'b0;
                  state_in = stat.cand_bad ? scp_pkg::S_FIN : scp_pkg::S_LK_RD;
               end
               scp_pkg::REQ_CHOOSE: begin
                  mode_in  = 1'b1;
                  state_in = stat.round_done ? scp_pkg::S_FIN : scp_pkg::S_CLR;
               end
               default: state_in = scp_pkg::S_FIN;
            endcase
         end
         scp_pkg::S_LK_RD: begin
            if (stat.lk_end) begin
               state_in = mode_ff ? scp_pkg::S_CH_NEXT : scp_pkg::S_ADD_NEW;
            end else begin
               state_in = scp_pkg::S_LK_CMP;
            end
         end
         scp_pkg::S_LK_CMP: begin
            if (stat.key_hit) begin
               state_in = mode_ff ? scp_pkg::S_CH_LEN : scp_pkg::S_ADD_LEN;
            end else begin
               state_in = scp_pkg::S_LK_RD;
            end
         end
         scp_pkg::S_ADD_NEW:    state_in = scp_pkg::S_FIN;
         scp_pkg::S_ADD_LEN:    state_in = scp_pkg::S_ADD_DUP_RD;
         scp_pkg::S_ADD_DUP_RD: begin
            state_in = stat.s_end ? scp_pkg::S_FIN : scp_pkg::S_ADD_DUP_CMP;
         end
         scp_pkg::S_ADD_DUP_CMP: begin
            state_in = stat.dup_hit ? scp_pkg::S_FIN : scp_pkg::S_ADD_DUP_RD;
         end
         scp_pkg::S_CLR: begin
            if (stat.clr_end) state_in = scp_pkg::S_CH_NEXT;
         end
         scp_pkg::S_CH_NEXT: begin
            if (stat.i_end) begin
               state_in = scp_pkg::S_FIN;
            end else if (!stat.i_found) begin
               state_in = scp_pkg::S_CH_KEY;
            end
         end
         scp_pkg::S_CH_KEY:    state_in = scp_pkg::S_LK_RD;
         scp_pkg::S_CH_LEN:    state_in = scp_pkg::S_CH_MEM_RD;
         scp_pkg::S_CH_MEM_RD: begin
            state_in = stat.s_end ? scp_pkg::S_CH_NEXT : scp_pkg::S_CH_MEM;
         end
         scp_pkg::S_CH_MEM: begin
            if (stat.mem_bad) begin
               state_in = scp_pkg::S_CH_MEM_RD;
            end else if (stat.mem_last) begin
               state_in = scp_pkg::S_UNDO_RD;
            end else begin
               state_in = scp_pkg::S_CH_SC;
            end
         end
         scp_pkg::S_CH_SC:   state_in = scp_pkg::S_CH_MEM_RD;
         scp_pkg::S_UNDO_RD: begin
            state_in = stat.t_end ? scp_pkg::S_CH_NEXT : scp_pkg::S_UNDO_MEM;
         end
         scp_pkg::S_UNDO_MEM: begin
            state_in = stat.mem_bad ? scp_pkg::S_UNDO_RD : scp_pkg::S_UNDO_SC;
         end
         scp_pkg::S_UNDO_SC: state_in = scp_pkg::S_UNDO_RD;
         scp_pkg::S_FIN: begin
            if (stat.rsp_free) state_in = scp_pkg::S_IDLE;
         end
         default: state_in = scp_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         scp_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         scp_pkg::S_DISPATCH: begin
            case (stat.req_code)
               scp_pkg::REQ_ADD: begin
                  if (stat.cand_bad) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = scp_pkg::ST_LIST_FULL;
                  end else begin
                     cmd.lk_start = 1'b1;
                  end
               end
               scp_pkg::REQ_APPEND: cmd.append_do = 1'b1;
               scp_pkg::REQ_CHOOSE: begin
                  if (stat.round_done) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = scp_pkg::ST_OK;
                  end else begin
                     cmd.ch_init = 1'b1;
                  end
               end
               scp_pkg::REQ_START: begin
                  cmd.start_round = 1'b1;
                  cmd.set_res     = 1'b1;
                  cmd.res_status  = scp_pkg::ST_OK;
               end
               scp_pkg::REQ_CLEAR: begin
                  cmd.clr_in     = 1'b1;
                  cmd.set_res    = 1'b1;
                  cmd.res_status = scp_pkg::ST_OK;
               end
               default: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = scp_pkg::ST_OK;
               end
            endcase
         end
         scp_pkg::S_LK_RD: begin
            if (stat.lk_end && mode_ff) cmd.i_step = 1'b1;
         end
         scp_pkg::S_LK_CMP: begin
            if (!stat.key_hit) cmd.lk_step = 1'b1;
         end
         scp_pkg::S_ADD_NEW: begin
            cmd.set_res = 1'b1;
            if (stat.used_full) begin
               cmd.res_status = scp_pkg::ST_IDX_FULL;
            end else begin
               cmd.add_new    = 1'b1;
               cmd.res_status = scp_pkg::ST_OK;
            end
         end
         scp_pkg::S_ADD_LEN: begin
            cmd.len_latch = 1'b1;
            cmd.s_clr     = 1'b1;
         end
         scp_pkg::S_ADD_DUP_RD: begin
            if (stat.s_end) begin
               cmd.set_res = 1'b1;
               if (stat.list_full) begin
                  cmd.res_status = scp_pkg::ST_LIST_FULL;
               end else begin
                  cmd.add_append = 1'b1;
                  cmd.res_status = scp_pkg::ST_OK;
               end
            end
         end
         scp_pkg::S_ADD_DUP_CMP: begin
            if (stat.dup_hit) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = scp_pkg::ST_OK;
            end else begin
               cmd.s_step = 1'b1;
            end
         end
         scp_pkg::S_CLR: begin
            cmd.clr_step = 1'b1;
            cmd.i_clr    = stat.clr_end;
         end
         scp_pkg::S_CH_NEXT: begin
            if (stat.i_end) begin
               cmd.choose_fin = 1'b1;
            end else if (stat.i_found) begin
               cmd.i_step = 1'b1;
            end
         end
         scp_pkg::S_CH_KEY: begin
            cmd.target_load = 1'b1;
            cmd.lk_start    = 1'b1;
         end
         scp_pkg::S_CH_LEN: begin
            cmd.len_latch = 1'b1;
            cmd.s_clr     = 1'b1;
         end
         scp_pkg::S_CH_MEM_RD: begin
            if (stat.s_end) cmd.i_step = 1'b1;
         end
         scp_pkg::S_CH_MEM: begin
            if (stat.mem_bad) begin
               cmd.s_step = 1'b1;
            end else if (stat.mem_last) begin
               cmd.mark_found = 1'b1;
            end else begin
               cmd.sc_latch = 1'b1;
            end
         end
         scp_pkg::S_CH_SC: begin
            cmd.sc_inc = 1'b1;
            cmd.s_step = 1'b1;
         end
         scp_pkg::S_UNDO_RD: begin
            cmd.mem_use_t = 1'b1;
            if (stat.t_end) cmd.i_step = 1'b1;
         end
         scp_pkg::S_UNDO_MEM: begin
            if (stat.mem_bad) begin
               cmd.t_step = 1'b1;
            end else begin
               cmd.sc_latch = 1'b1;
            end
         end
         scp_pkg::S_UNDO_SC: begin
            cmd.sc_dec = 1'b1;
            cmd.t_step = 1'b1;
         end
         scp_pkg::S_FIN: cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

[sv/scp_dpath.sv]
// Datapath with the index, incoming and score memories, counters and result registers.
module scp_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  scp_pkg::req_item_type         req_item,
   output scp_pkg::rsp_item_type         rsp_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         csr_valid,
   input  logic [scp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scp_pkg::CFG_W-1:0]     csr_data,
   input  scp_pkg::scp_cmd_type          cmd,
   output scp_pkg::scp_stat_type         stat
);

   // Control state.
   logic [scp_pkg::CFG_W-1:0]   champs_ff, champs_in;
   logic [scp_pkg::CFG_W-1:0]   nibble_ff, nibble_in;
   logic [scp_pkg::USED_W-1:0]  used_ff, used_in;
   logic [scp_pkg::INSZ_W-1:0]  size_ff, size_in;
   logic [scp_pkg::IN_MAX-1:0]  found_ff, found_in;
   logic                       last_valid_ff, last_valid_in;
   logic [scp_pkg::ROUND_W-1:0] round_ff, round_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Working registers.
   scp_pkg::req_item_type       req_ff, req_in;
   logic [scp_pkg::FP_W-1:0]    target_ff, target_in;
   logic [scp_pkg::USED_W-1:0]  e_ff, e_in;
   logic [scp_pkg::LEN_W-1:0]   n_ff, n_in;
   logic [scp_pkg::LEN_W-1:0]   s_ff, s_in;
   logic [scp_pkg::LEN_W-1:0]   t_ff, t_in;
   logic [scp_pkg::CAND_W-1:0]  k_ff, k_in;
   logic [scp_pkg::INSZ_W-1:0]  i_ff, i_in;
   logic [scp_pkg::CAND_W-1:0]  c_ff, c_in;
   logic [scp_pkg::CAND_W-1:0]  best_ff, best_in;
   logic [scp_pkg::SCORE_W-1:0] best_sc_ff, best_sc_in;
   logic                       have_best_ff, have_best_in;
   logic [scp_pkg::CAND_W-1:0]  last_ff, last_in;
   scp_pkg::rsp_item_type       res_ff, res_in;
   scp_pkg::rsp_item_type       rsp_ff, rsp_in;

   // Memory ports.
   logic [scp_pkg::FP_W-1:0]    key_rdata, in_rdata;
   logic [scp_pkg::LEN_W-1:0]   len_rdata;
   logic [scp_pkg::ID_W-1:0]    mem_rdata;
   logic [scp_pkg::SCORE_W-1:0] sc_rdata;
   logic                       len_we, in_we, sc_we;
   logic [scp_pkg::IDX_W-1:0]   len_waddr;
   logic [scp_pkg::LEN_W-1:0]   len_wdata;
   logic [scp_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
   logic [scp_pkg::LIST_W-1:0]  slot;
   logic [scp_pkg::CAND_W-1:0]  sc_waddr;
   logic [scp_pkg::SCORE_W-1:0] sc_wdata, sc_up, sc_dn;
   logic [scp_pkg::STAT_W-1:0]  app_status;
   logic                       nib_bad, in_full;

   assign nib_bad = req_ff.fingerprint[scp_pkg::FP_W-1 -: scp_pkg::CFG_W] != nibble_ff;
   assign in_full = size_ff == scp_pkg::INSZ_W'(scp_pkg::IN_MAX);

   always_comb begin
      if (nib_bad) begin
         app_status = scp_pkg::ST_NOT_HOOK;
      end else if (in_full) begin
         app_status = scp_pkg::ST_IN_FULL;
      end else begin
         app_status = scp_pkg::ST_OK;
      end
   end

   assign sc_up = (sc_rdata == scp_pkg::SCORE_TOP) ? sc_rdata : sc_rdata + 1'b1;
   assign sc_dn = (sc_rdata != '0) ? sc_rdata - 1'b1 : sc_rdata;

   // Status to the controller.
   always_comb begin
      stat            = '0;
      stat.req_code   = req_ff.req_type;
      stat.cand_bad   = 32'(req_ff.candidate_id) >= scp_pkg::CAND_MAX;
      stat.lk_end     = e_ff >= used_ff;
      stat.key_hit    = key_rdata == target_ff;
      stat.used_full  = used_ff == scp_pkg::USED_W'(scp_pkg::INDEX_ENTRIES);
      stat.s_end      = (s_ff >= n_ff) || (s_ff >= scp_pkg::LEN_W'(scp_pkg::LIST_MAX));
      stat.list_full  = n_ff >= scp_pkg::LEN_W'(scp_pkg::LIST_MAX);
      stat.dup_hit    = mem_rdata == req_ff.candidate_id;
      stat.round_done = round_ff >= champs_ff;
      stat.clr_end    = k_ff == scp_pkg::CAND_W'(scp_pkg::CAND_MAX - 1);
      stat.i_end      = i_ff >= size_ff;
      stat.i_found    = found_ff[i_ff[scp_pkg::IN_W-1:0]];
      stat.mem_bad    = 32'(mem_rdata) >= scp_pkg::CAND_MAX;
      stat.mem_last   = last_valid_ff && (scp_pkg::CAND_W'(mem_rdata) == last_ff);
      stat.t_end      = t_ff >= s_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Next values.
   always_comb begin
      champs_in     = champs_ff;
      nibble_in     = nibble_ff;
      used_in       = used_ff;
      size_in       = size_ff;
      found_in      = found_ff;
      last_valid_in = last_valid_ff;
      round_in      = round_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_in        = req_ff;
      target_in     = target_ff;
      e_in          = e_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      c_in          = c_ff;
      best_in       = best_ff;
      best_sc_in    = best_sc_ff;
      have_best_in  = have_best_ff;
      last_in       = last_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         unique case (csr_index)
            scp_pkg::CSR_CHAMPS_MAX:  champs_in = csr_data;
            scp_pkg::CSR_HOOK_NIBBLE: nibble_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         req_in    = req_item;
         target_in = req_item.fingerprint;
      end
      if (cmd.set_res) begin
         res_in        = '0;
         res_in.status = cmd.res_status;
      end
      if (cmd.lk_start)    e_in = '0;
      if (cmd.lk_step)     e_in = e_ff + 1'b1;
      if (cmd.add_new)     used_in = used_ff + 1'b1;
      if (cmd.len_latch)   n_in = len_rdata;
      if (cmd.s_clr)       s_in = '0;
      if (cmd.s_step)      s_in = s_ff + 1'b1;
      if (cmd.t_step)      t_in = t_ff + 1'b1;
      if (cmd.target_load) target_in = in_rdata;
      if (cmd.sc_latch)    c_in = scp_pkg::CAND_W'(mem_rdata);
      if (cmd.clr_in)      size_in = '0;
      if (cmd.i_clr)       i_in = '0;
      if (cmd.i_step)      i_in = i_ff + 1'b1;
      if (cmd.clr_step)    k_in = k_ff + 1'b1;

      if (cmd.append_do) begin
         res_in        = '0;
         res_in.status = app_status;
         if (app_status == scp_pkg::ST_OK) begin
            found_in[size_ff[scp_pkg::IN_W-1:0]] = 1'b0;
            size_in = size_ff + 1'b1;
         end
      end

      if (cmd.start_round) begin
         found_in      = '0;
         round_in      = '0;
         last_valid_in = 1'b0;
         last_in       = '0;
      end

      if (cmd.ch_init) begin
         k_in         = '0;
         best_in      = '0;
         best_sc_in   = '0;
         have_best_in = 1'b0;
      end

      if (cmd.mark_found) begin
         found_in[i_ff[scp_pkg::IN_W-1:0]] = 1'b1;
         t_in = '0;
      end

      // The best score tracks the stored score of the current best candidate.
      if (cmd.sc_inc) begin
         if (!have_best_ff || (c_ff != best_ff && sc_up > best_sc_ff)) begin
            best_in      = c_ff;
            best_sc_in   = sc_up;
            have_best_in = 1'b1;
         end else if (c_ff == best_ff) begin
            best_sc_in = sc_up;
         end
      end
      if (cmd.sc_dec && have_best_ff && c_ff == best_ff) begin
         best_sc_in = sc_dn;
      end

      if (cmd.choose_fin) begin
         res_in = '0;
         if (have_best_ff) begin
            round_in           = round_ff + 1'b1;
            last_valid_in      = 1'b1;
            last_in            = best_ff;
            res_in.champ_valid = 1'b1;
            res_in.champ_id    = scp_pkg::ID_W'(best_ff);
            res_in.champ_score = best_sc_ff;
         end
      end

      if (cmd.rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         champs_ff     <= scp_pkg::CHAMPS_RESET;
         nibble_ff     <= scp_pkg::NIBBLE_RESET;
         used_ff       <= '0;
         size_ff       <= '0;
         found_ff      <= '0;
         last_valid_ff <= 1'b0;
         round_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         champs_ff     <= champs_in;
         nibble_ff     <= nibble_in;
         used_ff       <= used_in;
         size_ff       <= size_in;
         found_ff      <= found_in;
         last_valid_ff <= last_valid_in;
         round_ff      <= round_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      target_ff    <= target_in;
      e_ff         <= e_in;
      n_ff         <= n_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      c_ff         <= c_in;
      best_ff      <= best_in;
      best_sc_ff   <= best_sc_in;
      have_best_ff <= have_best_in;
      last_ff      <= last_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // Memory addressing.
   assign len_we    = cmd.add_new || cmd.add_append;
   assign len_waddr = cmd.add_new ? used_ff[scp_pkg::IDX_W-1:0] : e_ff[scp_pkg::IDX_W-1:0];
   assign len_wdata = cmd.add_new ? scp_pkg::LEN_W'(1) : n_ff + 1'b1;
   assign mem_waddr = cmd.add_new ? {used_ff[scp_pkg::IDX_W-1:0], scp_pkg::LIST_W'(0)}
                                  : {e_ff[scp_pkg::IDX_W-1:0], n_ff[scp_pkg::LIST_W-1:0]};
   assign slot      = cmd.mem_use_t ? t_ff[scp_pkg::LIST_W-1:0] : s_ff[scp_pkg::LIST_W-1:0];
   assign mem_raddr = {e_ff[scp_pkg::IDX_W-1:0], slot};
   assign in_we     = cmd.append_do && (app_status == scp_pkg::ST_OK);
   assign sc_we     = cmd.clr_step || cmd.sc_inc || cmd.sc_dec;
   assign sc_waddr  = cmd.clr_step ? k_ff : c_ff;
   assign sc_wdata  = cmd.clr_step ? '0 : (cmd.sc_inc ? sc_up : sc_dn);

   scp_ram #(.WIDTH(scp_pkg::FP_W), .DEPTH(scp_pkg::INDEX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.add_new),
      .wr_addr (used_ff[scp_pkg::IDX_W-1:0]),
      .wr_data (req_ff.fingerprint),
      .rd_addr (e_ff[scp_pkg::IDX_W-1:0]),
      .rd_data (key_rdata)
   );

   scp_ram #(.WIDTH(scp_pkg::LEN_W), .DEPTH(scp_pkg::INDEX_ENTRIES)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (e_ff[scp_pkg::IDX_W-1:0]),
      .rd_data (len_rdata)
   );

   scp_ram #(.WIDTH(scp_pkg::ID_W), .DEPTH(scp_pkg::MEM_DEPTH)) u_member_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (mem_waddr),
      .wr_data (req_ff.candidate_id),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   scp_ram #(.WIDTH(scp_pkg::FP_W), .DEPTH(scp_pkg::IN_MAX)) u_incoming_ram (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (size_ff[scp_pkg::IN_W-1:0]),
      .wr_data (req_ff.fingerprint),
      .rd_addr (i_ff[scp_pkg::IN_W-1:0]),
      .rd_data (in_rdata)
   );

   scp_ram #(.WIDTH(scp_pkg::SCORE_W), .DEPTH(scp_pkg::CAND_MAX)) u_score_ram (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (sc_waddr),
      .wr_data (sc_wdata),
      .rd_addr (scp_pkg::CAND_W'(mem_rdata)),
      .rd_data (sc_rdata)
   );

endmodule

[sv/sparse_index_champion_chooser.sv]
// Top level of the sparse index champion chooser: controller plus datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_item (req_type, fingerprint, candidate_id)
//   rsp_      out        rsp_valid / rsp_ready  rsp_item (status, champ_valid, champ_id,
//                                                         champ_score)
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data (always ready)
//
// One item is worked on at a time; every item gives exactly one result item.
// An append, start round, clear or unknown request is handled at dispatch. An index add
// runs a linear key search over the stored keys, then checks each list slot for a
// duplicate. A choose sweeps the 256-entry score memory one entry a cycle, then for each
// unfound hook runs the same key search and walks the list members through the score
// memory.
// Reset is synchronous and clears counts, found bits, round state and the result valid flag.
// The result sits in an output register, so a stalled result does not block acceptance
// of the next item; that item's result waits for the register to free up.
module sparse_index_champion_chooser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  scp_pkg::req_item_type          req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output scp_pkg::rsp_item_type          rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scp_pkg::CFG_W-1:0]      csr_data
);

   scp_pkg::scp_cmd_type  cmd;
   scp_pkg::scp_stat_type stat;

   // Configuration writes are taken every cycle.
   assign csr_ready = 1'b1;

   scp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[dv/scp_checker.sv]
// Checker that predicts and compares every result item of the sparse index champion chooser.
module scp_checker
   import scp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_item_type           req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     index_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CFG_W-1:0]   champs_limit;
   logic [CFG_W-1:0]   hook_digit;
   logic [FP_W-1:0]    hook_keys [INDEX_ENTRIES];
   int                 key_list_len [INDEX_ENTRIES];
   logic [ID_W-1:0]    key_list [INDEX_ENTRIES][LIST_MAX];
   int                 keys_held;
   int                 tally [CAND_MAX];
   logic [FP_W-1:0]    arrivals [IN_MAX];
   logic               arrival_found [IN_MAX];
   int                 arrivals_held;
   logic               prior_valid;
   logic [ID_W-1:0]    prior_champ;
   int                 rounds_done;
   rsp_item_type       awaited_results [$];

   initial fail_count = 0;

   function automatic int find_key(input logic [FP_W-1:0] key);
      for (int e = 0; e < keys_held; e++) begin
         if (hook_keys[e] == key) return e;
      end
      return -1;
   endfunction

   function automatic rsp_item_type champion_outcome(input req_item_type req);
      rsp_item_type res;
      int           e, n, best;
      logic         have_best;
      logic [ID_W-1:0] c;
      res = '0;
      res.status = ST_OK;
      case (req.req_type)
         REQ_ADD: begin
            e = find_key(req.fingerprint);
            if (e >= 0) begin
               n = key_list_len[e];
               have_best = 1'b0;
               for (int s = 0; s < n; s++) begin
                  if (key_list[e][s] == req.candidate_id) have_best = 1'b1;
               end
               if (!have_best) begin
                  if (n >= LIST_MAX) begin
                     res.status = ST_LIST_FULL;
                  end else begin
                     key_list[e][n] = req.candidate_id;
                     key_list_len[e] = n + 1;
                  end
               end
            end else if (keys_held >= INDEX_ENTRIES) begin
               res.status = ST_IDX_FULL;
            end else begin
               hook_keys[keys_held] = req.fingerprint;
               key_list[keys_held][0] = req.candidate_id;
               key_list_len[keys_held] = 1;
               keys_held++;
            end
         end
         REQ_APPEND: begin
            if (req.fingerprint[FP_W-1 -: 4] != hook_digit) begin
               res.status = ST_NOT_HOOK;
            end else if (arrivals_held >= IN_MAX) begin
               res.status = ST_IN_FULL;
            end else begin
               arrivals[arrivals_held] = req.fingerprint;
               arrival_found[arrivals_held] = 1'b0;
               arrivals_held++;
            end
         end
         REQ_CHOOSE: begin
            if (rounds_done < champs_limit) begin
               have_best = 1'b0;
               best = 0;
               for (int k = 0; k < CAND_MAX; k++) tally[k] = 0;
               for (int i = 0; i < arrivals_held; i++) begin
                  if (arrival_found[i]) continue;
                  e = find_key(arrivals[i]);
                  if (e < 0) continue;
                  n = key_list_len[e];
                  for (int s = 0; s < n; s++) begin
                     c = key_list[e][s];
                     if (prior_valid && c == prior_champ) begin
                        // The previous champion already covers this hook: take back
                        // what this list gave so far and stop walking it.
                        arrival_found[i] = 1'b1;
                        for (int t = 0; t < s; t++) begin
                           if (tally[key_list[e][t]] > 0) tally[key_list[e][t]]--;
                        end
                        break;
                     end
                     if (tally[c] < int'(SCORE_TOP)) tally[c]++;
                     if (!have_best || tally[c] > tally[best]) begin
                        best = c;
                        have_best = 1'b1;
                     end
                  end
               end
               if (have_best) begin
                  rounds_done = (rounds_done + 1) % 16;
                  prior_valid = 1'b1;
                  prior_champ = best[ID_W-1:0];
                  res.champ_valid = 1'b1;
                  res.champ_id = best[ID_W-1:0];
                  res.champ_score = SCORE_W'(tally[best]);
               end
            end
         end
         REQ_START: begin
            for (int i = 0; i < IN_MAX; i++) arrival_found[i] = 1'b0;
            rounds_done = 0;
            prior_valid = 1'b0;
            prior_champ = '0;
         end
         REQ_CLEAR: arrivals_held = 0;
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         champs_limit = CHAMPS_RESET;
         hook_digit = NIBBLE_RESET;
         keys_held = 0;
         arrivals_held = 0;
         for (int i = 0; i < IN_MAX; i++) arrival_found[i] = 1'b0;
         prior_valid = 1'b0;
         prior_champ = '0;
         rounds_done = 0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CHAMPS_MAX) champs_limit = csr_data;
            else if (csr_index == CSR_HOOK_NIBBLE) hook_digit = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected result item %p", rsp_item);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.status !== want.status
                   || rsp_item.champ_valid !== want.champ_valid
                   || rsp_item.champ_id !== want.champ_id
                   || rsp_item.champ_score !== want.champ_score) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch: expected status %0d valid %0d id %0d score %0d,",
                              want.status, want.champ_valid, want.champ_id,
                              want.champ_score);
                     $display("          got status %0d valid %0d id %0d score %0d",
                              rsp_item.status, rsp_item.champ_valid, rsp_item.champ_id,
                              rsp_item.champ_score);
                  end
               end
            end
         end
         if (req_valid && req_ready) awaited_results.push_back(champion_outcome(req_item));
      end
      pending = awaited_results.size();
      index_count = keys_held;
   end

endmodule

[dv/testbench.sv]
// Top of the testbench: clock, reset, stimulus, result-side stalls and the verdict.
module testbench;
   import scp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Generous cycle budget: filling the whole index is a long run on its own.
   localparam int CYCLE_LIMIT = 20_000_000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_item_type         req_item;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_item_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   int                   fail_count;
   int                   pending;
   int                   index_count;

   // Stimulus-side knobs and shared state; calm and the hold counters feed the result side.
   logic                 calm;          // no idling on either side while set
   int                   hold_asks;     // bumped to request one long result stall
   int                   hold_served;
   int                   hold_left;
   logic [CFG_W-1:0]     cur_digit;     // hook nibble currently programmed
   logic [59:0]          key_bodies [32];
   int                   cycle_count;

   sparse_index_champion_chooser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   scp_checker result_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .index_count (index_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is cut off once it exceeds the cycle budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sparse_index_champion_chooser verification failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request. The hold is counted
   // here so that the sender keeps offering items while the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   // Offers one item and returns at the edge where it is accepted. Valid stays high into
   // the next item unless a random gap is taken first.
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [FP_W-1:0] fp,
                            input logic [ID_W-1:0] cand);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{req_type: kind, fingerprint: fp, candidate_id: cand};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Registers are only touched once every result is back and the block has gone quiet.
   task automatic reconfigure(input logic [CFG_W-1:0] champs, input logic [CFG_W-1:0] digit);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      write_reg(CSR_CHAMPS_MAX, champs);
      write_reg(CSR_HOOK_NIBBLE, digit);
      cur_digit = digit;
   endtask

   // A key from the small shared pool, tagged as a hook most of the time.
   function automatic logic [FP_W-1:0] pool_key(input int hook_pct);
      logic [CFG_W-1:0] tag;
      tag = ($urandom_range(99) < hook_pct) ? cur_digit : CFG_W'($urandom);
      return {tag, key_bodies[$urandom_range(31)]};
   endfunction

   function automatic logic [FP_W-1:0] any_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ID_W-1:0] some_candidate();
      return ($urandom_range(99) < 80) ? ID_W'($urandom_range(11)) : ID_W'($urandom);
   endfunction

   initial begin
      int                champs_plan [6];
      int                digit_plan [6];
      int                sent;
      int                pick;
      logic [FP_W-1:0]   crowded;

      champs_plan = '{1, 15, 2, 15, 0, 10};
      digit_plan  = '{0, 15, 7, 15, 0, 15};
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_asks = 0;
      hold_served = 0;
      hold_left = 0;
      cur_digit = NIBBLE_RESET;
      cycle_count = 0;
      for (int k = 0; k < 32; k++) key_bodies[k] = 60'({$urandom, $urandom});
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes, duplicates, a full list, hook filtering and a
      // round that runs out of champions.
      reconfigure(CFG_W'(3), CFG_W'(15));
      crowded = {4'hF, key_bodies[0]};
      send_item(REQ_ADD, '1, 0);
      send_item(REQ_ADD, {4'hF, 60'h0}, 255);
      send_item(REQ_ADD, '1, 0);                  // duplicate id is ignored
      send_item(REQ_ADD, '1, 5);
      for (int k = 0; k < 17; k++) send_item(REQ_ADD, crowded, ID_W'(k)); // last one overflows
      send_item(REQ_APPEND, '1, 0);
      send_item(REQ_APPEND, 64'h0, 0);            // wrong top nibble
      send_item(REQ_APPEND, crowded, 0);
      send_item(REQ_APPEND, {4'hF, 60'h0}, 0);
      repeat (4) send_item(REQ_CHOOSE, 0, 0);     // the last two chooses find no champion left
      send_item(REQ_START, '1, 255);
      send_item(REQ_CHOOSE, '1, 255);
      send_item(3'd5, 0, 0);
      send_item(3'd6, 0, 0);
      send_item(3'd7, '1, 255);
      send_item(REQ_CLEAR, 0, 0);
      send_item(REQ_CHOOSE, 0, 0);                // nothing incoming, so no champion

      // Fill the incoming list past its capacity and score the full list once.
      for (int k = 0; k < IN_MAX + 1; k++) send_item(REQ_APPEND, pool_key(100), 0);
      send_item(REQ_START, 0, 0);
      send_item(REQ_CHOOSE, 0, 0);
      send_item(REQ_CLEAR, 0, 0);

      // Random part: one phase per register setting. Most traffic forms whole rounds
      // (clear, appends, start, chooses); the rest is index growth and noise.
      for (int ph = 0; ph < 6; ph++) begin
         reconfigure(champs_plan[ph] == 0 ? CFG_W'($urandom_range(1, 15))
                                          : CFG_W'(champs_plan[ph]),
                     ph == 4 ? CFG_W'($urandom) : CFG_W'(digit_plan[ph]));
         calm = (ph == 1);
         if (ph == 2) hold_asks++;
         sent = 0;
         while (sent < 20) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               repeat ($urandom_range(2, 8)) begin
                  send_item(REQ_ADD, ($urandom_range(99) < 95) ? pool_key(90) : any_key(),
                            some_candidate());
                  sent++;
               end
            end else if (pick < 75) begin
               send_item(REQ_CLEAR, any_key(), ID_W'($urandom));
               repeat ($urandom_range(1, 10)) begin
                  send_item(REQ_APPEND, ($urandom_range(99) < 85) ? pool_key(95) : any_key(),
                            ID_W'($urandom));
                  sent++;
               end
               send_item(REQ_START, any_key(), ID_W'($urandom));
               repeat ($urandom_range(1, 4)) send_item(REQ_CHOOSE, any_key(), ID_W'($urandom));
               sent += 2;
            end else begin
               send_item(REQ_TYPE_ANY(), any_key(), ID_W'($urandom));
               sent++;
            end
         end
         calm = 1'b0;
      end

      // Grow the index to capacity, then check refusal of new keys and a final round.
      while (index_count < INDEX_ENTRIES) send_item(REQ_ADD, any_key(), some_candidate());
      repeat (3) send_item(REQ_ADD, any_key(), some_candidate());
      send_item(REQ_ADD, '1, 9);
      send_item(REQ_CLEAR, 0, 0);
      send_item(REQ_APPEND, pool_key(100), 0);
      send_item(REQ_APPEND, '1, 0);
      send_item(REQ_START, 0, 0);
      send_item(REQ_CHOOSE, 0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("sparse_index_champion_chooser verification clean");
      end else begin
         $display("sparse_index_champion_chooser verification failed");
      end
      $finish;
   end

   // Any request code, the unused ones included.
   function automatic logic [REQ_W-1:0] REQ_TYPE_ANY();
      return REQ_W'($urandom_range(7));
   endfunction

endmodule
